// File: design/pit_pkg.sv
package pit_pkg;

    // Command codes carried in the cmd field of an input item.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Port offsets from the timer base address.
    localparam logic [1:0] OFS_CH0  = 2'd0;
    localparam logic [1:0] OFS_CH1  = 2'd1;
    localparam logic [1:0] OFS_CTRL = 2'd3;

    // Counting modes.
    localparam logic [2:0] MODE_ONE_SHOT = 3'd0;
    localparam logic [2:0] MODE_RATE     = 3'd2;
    localparam logic [2:0] MODE_SQUARE   = 3'd3;

    // Access modes of the control word.
    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_LSB   = 2'd1;
    localparam logic [1:0] ACC_LOHI  = 2'd3;

    // Channel selections.
    localparam logic [1:0] CHAN_0 = 2'd0;
    localparam logic [1:0] CHAN_1 = 2'd1;

    // Control word field masks.
    localparam logic [7:0] CW_MODE_MASK = 8'h0E;
    localparam logic [7:0] CW_ACC_MASK  = 8'h30;
    localparam logic [7:0] CW_CHAN_MASK = 8'hC0;

    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] port_offset;
        logic [7:0] write_data;
    } t_pit_in;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] count_now;
    } t_pit_out;

endpackage

// File: design/pit_core.sv
module pit_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  pit_pkg::t_pit_in  i_item,
    output pit_pkg::t_pit_out o_result
);
    import pit_pkg::*;

    logic [15:0] r_count,   n_count;
    logic [15:0] r_reload,  n_reload;
    logic        r_loaded,  n_loaded;
    logic        r_pending, n_pending;
    logic        r_wr_high, n_wr_high;
    logic        r_latch,   n_latch;
    logic        r_rd_high, n_rd_high;
    logic        r_bcd,     n_bcd;
    logic [2:0]  r_mode,    n_mode;
    logic [1:0]  r_acc,     n_acc;
    logic [1:0]  r_chan,    n_chan;
    logic [7:0]  rd_byte;
    logic [15:0] dec_count;
    logic [7:0]  cw;

    assign cw = i_item.write_data;

    // Mode 2 steps by one, mode 3 by two.
    assign dec_count = r_count - ((r_mode == MODE_RATE) ? 16'd1 : 16'd2);

    always_comb begin
        n_count   = r_count;
        n_reload  = r_reload;
        n_loaded  = r_loaded;
        n_pending = r_pending;
        n_wr_high = r_wr_high;
        n_latch   = r_latch;
        n_rd_high = r_rd_high;
        n_bcd     = r_bcd;
        n_mode    = r_mode;
        n_acc     = r_acc;
        n_chan    = r_chan;
        rd_byte   = 8'd0;
        case (i_item.cmd)
            CMD_WRITE: begin
                case (i_item.port_offset)
                    OFS_CH0: begin
                        if (r_chan == CHAN_0 && r_acc == ACC_LOHI) begin
                            if (!r_wr_high) begin
                                n_reload[7:0] = i_item.write_data;
                                n_wr_high     = 1'b1;
                            end else begin
                                n_reload[15:8] = i_item.write_data;
                                n_loaded       = 1'b1;
                                n_pending      = 1'b1;
                                n_wr_high      = 1'b0;
                            end
                        end
                    end
                    OFS_CH1: begin
                        if (r_chan == CHAN_1 && r_acc == ACC_LSB) begin
                            n_reload[7:0] = i_item.write_data;
                            n_loaded      = 1'b1;
                            n_pending     = 1'b1;
                        end
                    end
                    OFS_CTRL: begin
                        n_bcd  = cw[0];
                        n_mode = 3'((cw & CW_MODE_MASK) >> 1);
                        n_acc  = 2'((cw & CW_ACC_MASK) >> 4);
                        n_chan = 2'((cw & CW_CHAN_MASK) >> 6);
                        if (2'((cw & CW_ACC_MASK) >> 4) == ACC_LATCH) begin
                            n_latch = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_READ: begin
                if (i_item.port_offset == OFS_CH1 && r_latch) begin
                    if (!r_rd_high) begin
                        n_rd_high = 1'b1;
                        rd_byte   = r_count[7:0];
                    end else begin
                        n_rd_high = 1'b0;
                        n_latch   = 1'b0;
                        rd_byte   = r_count[15:8];
                    end
                end
            end
            CMD_TICK: begin
                if (r_mode == MODE_ONE_SHOT) begin
                    if (r_loaded && !r_latch) begin
                        if (r_pending) begin
                            n_count   = r_reload;
                            n_pending = 1'b0;
                        end else begin
                            n_count = r_count - 16'd1;
                        end
                    end
                end else if (r_mode == MODE_RATE || r_mode == MODE_SQUARE) begin
                    if (r_loaded) begin
                        if (r_pending) begin
                            n_count   = r_reload;
                            n_pending = 1'b0;
                        end else if (dec_count == 16'd1) begin
                            n_count = r_reload;
                        end else begin
                            n_count = dec_count;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.read_data = rd_byte;
    assign o_result.count_now = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_reload  <= '0;
            r_loaded  <= 1'b0;
            r_pending <= 1'b0;
            r_wr_high <= 1'b0;
            r_latch   <= 1'b0;
            r_rd_high <= 1'b0;
            r_bcd     <= 1'b0;
            r_mode    <= '0;
            r_acc     <= '0;
            r_chan    <= '0;
        end else if (i_advance) begin
            r_count   <= n_count;
            r_reload  <= n_reload;
            r_loaded  <= n_loaded;
            r_pending <= n_pending;
            r_wr_high <= n_wr_high;
            r_latch   <= n_latch;
            r_rd_high <= n_rd_high;
            r_bcd     <= n_bcd;
            r_mode    <= n_mode;
            r_acc     <= n_acc;
            r_chan    <= n_chan;
        end
    end

endmodule

// File: design/pit_out_reg.sv
module pit_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  pit_pkg::t_pit_out i_result,
    input  logic              i_out_ready,
    output logic              o_space,
    output logic              o_out_valid,
    output pit_pkg::t_pit_out o_out_data
);
    import pit_pkg::*;

    logic     r_valid;
    t_pit_out r_data;

    // The register can take a new result when empty or when it drains now.
    assign o_space     = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

endmodule

// File: design/interval_timer_with_port_programming.sv
// Interval timer with a byte-wide programming port, modeled on the classic
// three-channel interval timer but with one working counter.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): each transfer carries
// one command, a port write, a port read or a timer tick, with the port
// offset and the write byte. Output channel (o_out_valid / i_out_ready /
// o_out_data): exactly one result per command, in order, holding the byte
// returned by a read (zero otherwise) and the counter value after the command.
//
// The result of a command passes the input register and then the output
// register before it transfers out. Throughput is one command per cycle: the
// input register hands its command to the timer logic and the output register
// in the same cycle, so a new command can be taken every cycle while the
// output keeps draining.
//
// Reset (synchronous, active low) clears the counter, the reload value, the
// control word and all sequencing flags, and empties both registers.
// When the receiver stalls, the result waits in the output register, the
// next command waits in the input register, and o_in_ready falls once both
// are full; nothing is dropped and the timer state does not move.
module interval_timer_with_port_programming (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pit_pkg::t_pit_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pit_pkg::t_pit_out o_out_data
);
    import pit_pkg::*;

    logic     r_in_valid;
    t_pit_in  r_in_data;
    logic     out_space;
    logic     advance;
    t_pit_out result;

    // A held command moves on whenever the output register has room. The
    // timer state updates in that same cycle, so state and results stay in
    // step with the order of commands.
    assign advance    = r_in_valid && out_space;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    pit_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_data),
        .o_result  (result)
    );

    pit_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_result    (result),
        .i_out_ready (i_out_ready),
        .o_space     (out_space),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// File: design/pit_checker.sv
module pit_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input pit_pkg::t_pit_out o_out_data
);
    import pit_pkg::*;

    // A stalled result holds its place and its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("output result changed or vanished while stalled");

    // Reset empties the output register.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // With an empty output register the input side is never blocked.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled while output register is empty");

    // A command taken while the output is empty yields a result once it has passed both registers.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> ##1 o_out_valid)
        else $error("result missing two cycles after an input transfer");

endmodule

bind interval_timer_with_port_programming pit_checker u_pit_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// File: tb/sv/tb_interval_timer_with_port_programming.sv
`timescale 1ns / 1ps

module tb_interval_timer_with_port_programming;

    import pit_pkg::*;

    // Codes that the package leaves unnamed but the stimulus still has to reach.
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [1:0] OFS_UNUSED   = 2'd2;
    localparam logic [1:0] CHAN_UNUSED  = 2'd3;
    localparam logic [2:0] MODE_NO_TICK = 3'd7;

    // Item counts that steer the random part of the run.
    localparam int RANDOM_TARGET = 1400;
    localparam int FINAL_TARGET  = 1720;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_pit_in   i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_pit_out  o_out_data;

    interval_timer_with_port_programming i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // The clock runs with a 10 ns period, low for the first half.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Our own copy of the timer state. It starts at the reset values and only
    // moves when a transfer is accepted on the input side.
    logic [15:0] tmr_count          = '0;
    logic [15:0] tmr_reload         = '0;
    logic        tmr_loaded         = 1'b0;
    logic        tmr_reload_pending = 1'b0;
    logic        tmr_write_high     = 1'b0;
    logic        tmr_latched        = 1'b0;
    logic        tmr_read_high      = 1'b0;
    logic        tmr_bcd            = 1'b0;
    logic [2:0]  tmr_mode           = '0;
    logic [1:0]  tmr_access         = '0;
    logic [1:0]  tmr_channel        = '0;

    // Results the block still owes us, oldest first.
    t_pit_out timer_outputs_due[$];
    t_pit_out due_output;

    int  mismatches = 0;
    int  items_sent = 0;
    bit  tx_idling = 1'b1;
    bit  rx_idling = 1'b1;
    int  rx_hold_request = 0;

    // Applies one command to the timer copy and returns the result the block
    // must produce for it: the read byte and the counter after the command.
    function automatic t_pit_out timer_apply(input t_pit_in item);
        t_pit_out res;
        res.read_data = '0;
        case (item.cmd)
            CMD_WRITE: begin
                case (item.port_offset)
                    OFS_CH0: begin
                        // Channel 0 takes the reload as a low byte, then a high byte.
                        if (tmr_channel == CHAN_0 && tmr_access == ACC_LOHI) begin
                            if (!tmr_write_high) begin
                                tmr_reload[7:0] = item.write_data;
                                tmr_write_high  = 1'b1;
                            end else begin
                                tmr_reload[15:8]   = item.write_data;
                                tmr_loaded         = 1'b1;
                                tmr_reload_pending = 1'b1;
                                tmr_write_high     = 1'b0;
                            end
                        end
                    end
                    OFS_CH1: begin
                        // Channel 1 only replaces the low byte of the reload.
                        if (tmr_channel == CHAN_1 && tmr_access == ACC_LSB) begin
                            tmr_reload[7:0]    = item.write_data;
                            tmr_loaded         = 1'b1;
                            tmr_reload_pending = 1'b1;
                        end
                    end
                    OFS_CTRL: begin
                        // The control word never touches the read byte order.
                        tmr_bcd     = item.write_data[0];
                        tmr_mode    = item.write_data[3:1];
                        tmr_access  = item.write_data[5:4];
                        tmr_channel = item.write_data[7:6];
                        if (tmr_access == ACC_LATCH) begin
                            tmr_latched = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_READ: begin
                // Only a latched read at offset 1 returns data.
                if (item.port_offset == OFS_CH1 && tmr_latched) begin
                    if (!tmr_read_high) begin
                        tmr_read_high = 1'b1;
                        res.read_data = tmr_count[7:0];
                    end else begin
                        tmr_read_high = 1'b0;
                        tmr_latched   = 1'b0;
                        res.read_data = tmr_count[15:8];
                    end
                end
            end
            CMD_TICK: begin
                if (tmr_mode == MODE_ONE_SHOT) begin
                    // A pending latch freezes the one-shot count.
                    if (tmr_loaded && !tmr_latched) begin
                        if (tmr_reload_pending) begin
                            tmr_count          = tmr_reload;
                            tmr_reload_pending = 1'b0;
                        end else begin
                            tmr_count = tmr_count - 16'd1;
                        end
                    end
                end else if ((tmr_mode == MODE_RATE || tmr_mode == MODE_SQUARE) &&
                             tmr_loaded) begin
                    if (tmr_reload_pending) begin
                        tmr_count          = tmr_reload;
                        tmr_reload_pending = 1'b0;
                    end else begin
                        tmr_count = tmr_count - ((tmr_mode == MODE_RATE) ? 16'd1 : 16'd2);
                        if (tmr_count == 16'd1) begin
                            tmr_count = tmr_reload;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        res.count_now = tmr_count;
        return res;
    endfunction

    function automatic logic [7:0] control_word(input logic [1:0] chan, input logic [1:0] acc,
                                                input logic [2:0] mode, input logic bcd);
        return {chan, acc, mode, bcd};
    endfunction

    // Prints one line per mismatch, up to a cap, and always counts it.
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatches < 100) begin
            $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Offers one command and holds it until the block takes it. The call starts
    // and ends at a falling edge. Valid stays high on return, so a following
    // call keeps the channel busy without a bubble; a sender gap lowers it.
    task automatic send_item(input logic [1:0] cmd, input logic [1:0] ofs,
                             input logic [7:0] data);
        t_pit_in item;
        int      gap;
        item.cmd         = cmd;
        item.port_offset = ofs;
        item.write_data  = data;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        timer_outputs_due.push_back(timer_apply(item));
        items_sent++;
        @(negedge i_clk);
        if (tx_idling && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Stops offering commands and waits at falling edges until every owed
    // result has been seen by the checker.
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (timer_outputs_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Checker: every result transfer is compared field by field with the
    // oldest owed result. A result arriving with nothing owed is an error too.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (timer_outputs_due.size() == 0) begin
                report_mismatch("unrequested result count_now", o_out_data.count_now, '0);
            end else begin
                due_output = timer_outputs_due.pop_front();
                if (o_out_data.read_data !== due_output.read_data) begin
                    report_mismatch("read_data", 16'(o_out_data.read_data),
                                    16'(due_output.read_data));
                end
                if (o_out_data.count_now !== due_output.count_now) begin
                    report_mismatch("count_now", o_out_data.count_now, due_output.count_now);
                end
            end
        end
    end

    // Receiver: drives ready at each falling edge. A hold-off request from a
    // test is counted down here; otherwise short random stalls are thrown in
    // while receiver idling is enabled.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (rx_hold_request > 0) begin
                stall_left = rx_hold_request - 1;
                rx_hold_request = 0;
                i_out_ready <= 1'b0;
            end else if (rx_idling && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Before anything is programmed: ticks do nothing, every read returns zero,
    // and the unused command code leaves the state alone.
    task automatic test_unprogrammed_timer();
        send_item(CMD_TICK, OFS_CH0, 8'h00);
        send_item(CMD_READ, OFS_CH0, 8'hFF);
        send_item(CMD_READ, OFS_CH1, 8'h00);
        send_item(CMD_READ, OFS_UNUSED, 8'h00);
        send_item(CMD_READ, OFS_CTRL, 8'h00);
        send_item(CMD_UNUSED, OFS_CTRL, 8'hFF);
    endtask

    // Square wave mode programmed through the two-byte port. A reload of 3
    // reaches 1 after one step of two and reloads; a reload of 0xFFFF shows
    // the largest value being loaded.
    task automatic test_lohi_square_wave();
        send_item(CMD_WRITE, OFS_CTRL, control_word(CHAN_0, ACC_LOHI, MODE_SQUARE, 1'b1));
        send_item(CMD_WRITE, OFS_CH0, 8'h03);
        send_item(CMD_WRITE, OFS_CH0, 8'h00);
        send_item(CMD_TICK, OFS_CH0, 8'h00);
        send_item(CMD_TICK, OFS_CH0, 8'h00);
        send_item(CMD_WRITE, OFS_CH0, 8'hFF);
        send_item(CMD_WRITE, OFS_CH0, 8'hFF);
        send_item(CMD_TICK, OFS_CH0, 8'h00);
        send_item(CMD_TICK, OFS_CH0, 8'h00);
    endtask

    // One-shot mode with a reload of zero: the first step down wraps to 0xFFFF.
    task automatic test_one_shot_wrap();
        send_item(CMD_WRITE, OFS_CTRL, control_word(CHAN_0, ACC_LOHI, MODE_ONE_SHOT, 1'b0));
        send_item(CMD_WRITE, OFS_CH0, 8'h00);
        send_item(CMD_WRITE, OFS_CH0, 8'h00);
        send_item(CMD_TICK, OFS_CH0, 8'h00);
        send_item(CMD_TICK, OFS_CH0, 8'h00);
    endtask

    // The latch freezes the one-shot count. Re-arming between the two reads
    // keeps the byte order, the high byte clears the latch, and a further
    // read gets zero.
    task automatic test_latch_readback();
        send_item(CMD_WRITE, OFS_CTRL, control_word(CHAN_0, ACC_LATCH, MODE_ONE_SHOT, 1'b0));
        send_item(CMD_TICK, OFS_CH0, 8'h00);
        send_item(CMD_READ, OFS_CH1, 8'h00);
        send_item(CMD_WRITE, OFS_CTRL, control_word(CHAN_0, ACC_LATCH, MODE_ONE_SHOT, 1'b0));
        send_item(CMD_READ, OFS_CH1, 8'h00);
        send_item(CMD_READ, OFS_CH1, 8'h00);
        send_item(CMD_TICK, OFS_CH0, 8'h00);
    endtask

    // Rate generator on channel 1 with a low-byte reload: it counts to 1 and
    // reloads.
    task automatic test_lsb_rate_generator();
        send_item(CMD_WRITE, OFS_CTRL, control_word(CHAN_1, ACC_LSB, MODE_RATE, 1'b0));
        send_item(CMD_WRITE, OFS_CH1, 8'h03);
        repeat (3) send_item(CMD_TICK, OFS_CH0, 8'h00);
    endtask

    // Writes that the block must ignore, and a mode in which ticks do nothing.
    task automatic test_ignored_items();
        send_item(CMD_WRITE, OFS_CTRL, control_word(CHAN_UNUSED, ACC_LOHI, MODE_NO_TICK, 1'b1));
        send_item(CMD_WRITE, OFS_CH0, 8'hA5);
        send_item(CMD_WRITE, OFS_CH1, 8'h5A);
        send_item(CMD_WRITE, OFS_UNUSED, 8'hFF);
        send_item(CMD_TICK, OFS_CH0, 8'h00);
    endtask

    // One random timer program: a control word, the reload bytes, then a run
    // of ticks mixed with latched read-backs and the odd random command. Now
    // and then the high byte is left out, which shifts the byte order of the
    // next program.
    task automatic run_timer_program();
        logic [2:0]  mode;
        logic [15:0] reload;
        logic        bcd;
        int          pick;
        int          steps;
        pick   = $urandom_range(0, 9);
        mode   = (pick < 3) ? MODE_ONE_SHOT : (pick < 6) ? MODE_RATE :
                 (pick < 9) ? MODE_SQUARE : 3'($urandom);
        reload = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
        bcd    = 1'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            send_item(CMD_WRITE, OFS_CTRL, control_word(CHAN_1, ACC_LSB, mode, bcd));
            send_item(CMD_WRITE, OFS_CH1, reload[7:0]);
        end else begin
            send_item(CMD_WRITE, OFS_CTRL, control_word(CHAN_0, ACC_LOHI, mode, bcd));
            send_item(CMD_WRITE, OFS_CH0, reload[7:0]);
            if ($urandom_range(0, 9) != 0) begin
                send_item(CMD_WRITE, OFS_CH0, reload[15:8]);
            end
        end
        steps = $urandom_range(1, 40);
        repeat (steps) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_item(CMD_WRITE, OFS_CTRL, control_word(2'($urandom), ACC_LATCH, mode, bcd));
                repeat ($urandom_range(1, 3)) send_item(CMD_READ, OFS_CH1, 8'($urandom));
            end else if (pick == 1) begin
                send_item(2'($urandom), 2'($urandom), 8'($urandom));
            end else begin
                send_item(CMD_TICK, 2'($urandom), 8'($urandom));
            end
        end
    endtask

    // The receiver holds off for a long stretch while commands keep coming,
    // so both internal registers fill and the input side stalls. The sender
    // then pauses until everything owed has drained. Valid is lowered while
    // the request reaches the receiver, so the last command is not taken twice.
    task automatic test_receiver_holdoff();
        rx_hold_request = 80;
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        repeat (24) send_item(CMD_TICK, OFS_CH0, 8'h00);
        wait_results_drained();
    endtask

    // The bulk of the run, with random gaps on both sides.
    task automatic test_random_programs();
        while (items_sent < RANDOM_TARGET) begin
            run_timer_program();
        end
    endtask

    // The last part runs with no gaps on either side, one command per cycle.
    task automatic test_back_to_back();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        while (items_sent < FINAL_TARGET) begin
            run_timer_program();
        end
    endtask

    initial begin
        // Reset is held from the start and released at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_unprogrammed_timer();
        test_lohi_square_wave();
        test_one_shot_wrap();
        test_latch_readback();
        test_lsb_rate_generator();
        test_ignored_items();
        test_receiver_holdoff();
        test_random_programs();
        test_back_to_back();

        wait_results_drained();
        // Let any stray result show up before the verdict.
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("interval_timer_with_port_programming test passed");
        end else begin
            $display("interval_timer_with_port_programming test failed");
        end
        $finish;
    end

    // Watchdog: a hang anywhere in the run ends it as a failure.
    initial begin
        #5_000_000;
        $display("interval_timer_with_port_programming test failed");
        $finish;
    end

endmodule
